// ----- design/lps_pkg.sv -----
package lps_pkg;

  // Default sizes of the table and the shuffle.
  localparam int DEF_TABLE_SIZE     = 256;
  localparam int DEF_SHUFFLE_ROUNDS = 20;

  // Register reset values.
  localparam logic [31:0] RST_LCG_MULT = 32'd1664525;
  localparam logic [31:0] RST_LCG_INCR = 32'd1013904223;
  localparam logic [31:0] RST_LCG_MOD  = 32'd0;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_LCG_MULT = 2'd0;
  localparam logic [1:0] REG_LCG_INCR = 2'd1;
  localparam logic [1:0] REG_LCG_MOD  = 2'd2;

  // Action codes carried in tuser.
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_SHUFFLE = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  // Operand selection for the remainder units.
  localparam logic [1:0] MOD_SEL_INC  = 2'd0;
  localparam logic [1:0] MOD_SEL_DRAW = 2'd1;
  localparam logic [1:0] MOD_SEL_IDX  = 2'd2;

  typedef struct packed {
    logic [31:0] mult;
    logic [31:0] incr;
    logic [31:0] modulus;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       load_seed;
    logic       mod_start;
    logic [1:0] mod_sel;
    logic       inc_raw;
    logic       inc_mod;
    logic       mul;
    logic       add;
    logic       fill_wr;
    logic       pos_adv;
    logic       round_adv;
    logic       pick_draw;
    logic       pick_idx;
    logic       pick_mod;
    logic       rd;
    logic       wr_i;
    logic       wr_pick;
    logic       out_load;
    logic       out_is_read;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic mod_busy;
    logic mod_done;
    logic pos_last;
    logic round_last;
  } sts_t;

endpackage

// ----- design/lps_modulo.sv -----
module lps_modulo
  import lps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] remainder
);

  // Restoring remainder, one dividend bit per cycle.
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] div_r, div_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] trial;

  always_comb begin
    trial    = {rem_r, dvd_r[31]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[31:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ----- design/lps_datapath.sv -----
module lps_datapath
  import lps_pkg::*;
#(
  parameter int TABLE_SIZE     = DEF_TABLE_SIZE,
  parameter int SHUFFLE_ROUNDS = DEF_SHUFFLE_ROUNDS
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  logic [31:0] in_seed,
  input  logic [8:0]  in_index,
  output sts_t        sts,
  output logic [7:0]  entry_byte,
  output logic [31:0] rand_value
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int ROUND_W = (SHUFFLE_ROUNDS > 1) ? $clog2(SHUFFLE_ROUNDS) : 1;
  // Reciprocal of the table size, scaled so that the estimated quotient is
  // at most one below the true one for any 32-bit operand.
  localparam int          RECIP_SH = 31 + IDX_W;
  localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / TABLE_SIZE);
  localparam logic [31:0] TSIZE_32 = 32'(TABLE_SIZE);

  logic [31:0]      state_r, prod_r, inc_r;
  logic [8:0]       idx_r;
  logic [IDX_W-1:0] pos_r, pick_r, rd_a_r, rd_b_r;
  logic [ROUND_W-1:0] round_r;
  logic [IDX_W-1:0] mem [TABLE_SIZE];

  logic [31:0]      mod_rem;
  logic             mod_busy, mod_done;
  logic             div_start, cm_start;
  logic [31:0]      cm_x, cm_quot;
  logic [31:0]      cm_x_r, cm_diff_r, cm_res_r;
  logic [63:0]      cm_prod_r;
  logic [2:0]       cm_vld_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_wdata;
  logic             pos_last, round_last;

  // The increment goes through the serial unit, remainders by the table size
  // through the reciprocal pipeline.
  always_comb begin
    div_start = cmd.mod_start && (cmd.mod_sel == MOD_SEL_INC);
    cm_start  = cmd.mod_start && (cmd.mod_sel != MOD_SEL_INC);
    case (cmd.mod_sel)
      MOD_SEL_DRAW: cm_x = state_r;
      MOD_SEL_IDX:  cm_x = {23'd0, idx_r};
      default:      cm_x = state_r;
    endcase
  end

  lps_modulo u_modulo (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (cfg.incr),
    .divisor   (cfg.modulus),
    .busy      (mod_busy),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Remainder by the table size, registered in order: reciprocal multiply,
  // subtract the quotient times the size, then one correcting subtract.
  assign cm_quot = 32'(cm_prod_r >> RECIP_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_vld_r <= '0;
    end else begin
      cm_vld_r <= {cm_vld_r[1:0], cm_start};
    end
    if (cm_start) begin
      cm_x_r    <= cm_x;
      cm_prod_r <= 64'(cm_x) * 64'(RECIP);
    end
    cm_diff_r <= cm_x_r - cm_quot * TSIZE_32;
    cm_res_r  <= (cm_diff_r >= TSIZE_32) ? cm_diff_r - TSIZE_32 : cm_diff_r;
  end

  assign pos_last   = (pos_r == IDX_W'(TABLE_SIZE - 1));
  assign round_last = (round_r == ROUND_W'(SHUFFLE_ROUNDS - 1));

  // Generator, increment and index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (cmd.accept && cmd.load_seed) begin
      state_r <= in_seed;
    end else if (cmd.add) begin
      state_r <= prod_r + inc_r;
    end
    if (cmd.mul) begin
      prod_r <= cfg.mult * state_r;
    end
    if (cmd.inc_raw) begin
      inc_r <= cfg.incr;
    end else if (cmd.inc_mod) begin
      inc_r <= mod_rem;
    end
    if (cmd.accept) begin
      idx_r <= in_index;
    end
    if (cmd.pick_draw) begin
      pick_r <= state_r[IDX_W-1:0];
    end else if (cmd.pick_idx) begin
      pick_r <= IDX_W'({23'd0, idx_r});
    end else if (cmd.pick_mod) begin
      pick_r <= cm_res_r[IDX_W-1:0];
    end
  end

  // Position and round counters both wrap back to zero at their ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      round_r <= '0;
    end else if (cmd.pos_adv) begin
      pos_r <= pos_last ? '0 : pos_r + IDX_W'(1);
      if (cmd.round_adv && pos_last) begin
        round_r <= round_last ? '0 : round_r + ROUND_W'(1);
      end
    end
  end

  // Table memory: one write port, two registered read ports.
  always_comb begin
    mem_we    = cmd.fill_wr | cmd.wr_i | cmd.wr_pick;
    mem_waddr = cmd.wr_pick ? pick_r : pos_r;
    if (cmd.fill_wr) begin
      mem_wdata = pos_r;
    end else if (cmd.wr_i) begin
      mem_wdata = rd_b_r;
    end else begin
      mem_wdata = rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_a_r <= mem[pos_r];
      rd_b_r <= mem[pick_r];
    end
  end

  assign sts.mod_zero   = (cfg.modulus == 32'd0);
  assign sts.mod_busy   = mod_busy;
  assign sts.mod_done   = mod_done | cm_vld_r[2];
  assign sts.pos_last   = pos_last;
  assign sts.round_last = round_last;

  assign entry_byte = 8'(rd_b_r);
  assign rand_value = state_r;

endmodule

// ----- design/lps_controller.sv -----
module lps_controller
  import lps_pkg::*;
#(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  input  logic       out_free,
  input  sts_t       sts,
  output logic       in_ready,
  output cmd_t       cmd
);

  localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  localparam logic [3:0] S_FILL  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INC   = 4'd2;
  localparam logic [3:0] S_INCW  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_PICK  = 4'd6;
  localparam logic [3:0] S_PICKW = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_WR1   = 4'd9;
  localparam logic [3:0] S_WR2   = 4'd10;
  localparam logic [3:0] S_IDX   = 4'd11;
  localparam logic [3:0] S_IDXW  = 4'd12;
  localparam logic [3:0] S_RDE   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] action_r, action_nxt;
  logic [3:0] after_inc;

  assign after_inc = (action_r == ACT_SHUFFLE) ? S_FILL : S_MUL;

  always_comb begin
    state_nxt  = state_r;
    action_nxt = action_r;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.out_is_read = (action_r == ACT_READ);
    case (state_r)
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.pos_adv = 1'b1;
        if (sts.pos_last) begin
          state_nxt = (action_r == ACT_SHUFFLE) ? S_MUL : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          action_nxt = in_action;
          case (in_action)
            ACT_LOAD: begin
              cmd.load_seed = 1'b1;
              state_nxt     = S_DONE;
            end
            ACT_STEP:    state_nxt = S_INC;
            ACT_SHUFFLE: state_nxt = S_INC;
            default:     state_nxt = S_IDX;
          endcase
        end
      end
      S_INC: begin
        if (sts.mod_zero) begin
          cmd.inc_raw = 1'b1;
          state_nxt   = after_inc;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MOD_SEL_INC;
          state_nxt     = S_INCW;
        end
      end
      S_INCW: begin
        if (sts.mod_done) begin
          cmd.inc_mod = 1'b1;
          state_nxt   = after_inc;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = (action_r == ACT_STEP) ? S_DONE : S_PICK;
      end
      S_PICK: begin
        if (POW2) begin
          cmd.pick_draw = 1'b1;
          state_nxt     = S_RD;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MOD_SEL_DRAW;
          state_nxt     = S_PICKW;
        end
      end
      S_PICKW: begin
        if (sts.mod_done) begin
          cmd.pick_mod = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        cmd.wr_i  = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr_pick   = 1'b1;
        cmd.pos_adv   = 1'b1;
        cmd.round_adv = 1'b1;
        state_nxt     = (sts.pos_last && sts.round_last) ? S_DONE : S_MUL;
      end
      S_IDX: begin
        if (POW2) begin
          cmd.pick_idx = 1'b1;
          state_nxt    = S_RDE;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MOD_SEL_IDX;
          state_nxt     = S_IDXW;
        end
      end
      S_IDXW: begin
        if (sts.mod_done) begin
          cmd.pick_mod = 1'b1;
          state_nxt    = S_RDE;
        end
      end
      S_RDE: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Reset starts with the identity fill of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FILL;
      action_r <= ACT_LOAD;
    end else begin
      state_r  <= state_nxt;
      action_r <= action_nxt;
    end
  end

endmodule

// ----- design/lcg_permutation_shuffler.sv -----
// Permutation table with a 32-bit linear congruential generator.
// Input words arrive on in_t*: tuser carries the action (load seed, step,
// shuffle, read) and tdata the seed and the table index. Every accepted word
// yields exactly one result word on out_t*: the table entry for a read (zero
// otherwise) and the generator state once the action is complete.
// The generator constants are written over the APB-style cfg_ port; the user
// must write them only while idle, which the block itself does not enforce.
// Items are handled one at a time. A load needs no further work; a step runs
// the generator multiply and add, after the serial remainder unit when the
// modulus is nonzero; a read reads the table, after the reciprocal remainder
// when the table size is not a power of two. A shuffle rewrites the identity,
// then for each position of each round makes a draw, the two-entry read and
// the two writes that each position needs on the single write port of the
// table; a table size that is not a power of two adds the reciprocal
// remainder to each draw, and a nonzero modulus runs the serial unit once.
// After reset the block writes the identity into the table and holds
// in_tready low meanwhile; configuration writes are taken.
// A result that waits on a stalled receiver stays in the output register;
// the next input word is still accepted and its result waits behind it.
module lcg_permutation_shuffler
  import lps_pkg::*;
#(
  parameter int TABLE_SIZE     = DEF_TABLE_SIZE,
  parameter int SHUFFLE_ROUNDS = DEF_SHUFFLE_ROUNDS
)
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // seed_value[31:0], entry_index[40:32], zero
  input  logic [1:0]  in_tuser,   // action
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // entry_value[7:0], random_value[39:8]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r;
  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_wr;
  logic        out_free;
  logic [7:0]  entry_byte;
  logic [31:0] rand_value;
  logic        out_tvalid_r;
  logic [7:0]  out_entry_r;
  logic [31:0] out_random_r;

  // Configuration registers. Writes to addresses past the list are dropped.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mult    <= RST_LCG_MULT;
      cfg_r.incr    <= RST_LCG_INCR;
      cfg_r.modulus <= RST_LCG_MOD;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_LCG_MULT: cfg_r.mult    <= cfg_pwdata;
        REG_LCG_INCR: cfg_r.incr    <= cfg_pwdata;
        REG_LCG_MOD:  cfg_r.modulus <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LCG_MULT: cfg_prdata = cfg_r.mult;
      REG_LCG_INCR: cfg_prdata = cfg_r.incr;
      REG_LCG_MOD:  cfg_prdata = cfg_r.modulus;
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // The output register frees up in the same cycle that its word is taken.
  assign out_free = !out_tvalid_r || out_tready;

  lps_controller #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_controller (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .out_free  (out_free),
    .sts       (sts),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  lps_datapath #(
    .TABLE_SIZE     (TABLE_SIZE),
    .SHUFFLE_ROUNDS (SHUFFLE_ROUNDS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .in_seed    (in_tdata[31:0]),
    .in_index   (in_tdata[40:32]),
    .sts        (sts),
    .entry_byte (entry_byte),
    .rand_value (rand_value)
  );

  // Result register between the block and the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_entry_r  <= cmd.out_is_read ? entry_byte : 8'd0;
      out_random_r <= rand_value;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_random_r, out_entry_r};

`ifndef SYNTH
  a_mod_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_start |-> !sts.mod_busy)
    else $error("remainder unit started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("pending result overwritten");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted before the first was handled");

  a_fill_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted before the table fill");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for lcg_permutation_shuffler.
//
// A driver and a monitor sit on the two stream channels as clocked always
// blocks. The initial block fills the queue of pending input words phase by
// phase and reprograms the generator constants over the APB-style port
// between phases, once the block is idle. Every word the block accepts is run
// through a local copy of the permutation table and the generator, and the
// resulting entry and generator state go into a queue of due results. The
// monitor pops the oldest one for each result word and compares both fields.
module tb_top;
  import lps_pkg::*;

  localparam int TBL_SIZE       = DEF_TABLE_SIZE;
  localparam int TBL_ROUNDS     = DEF_SHUFFLE_ROUNDS;
  // A shuffle holds the input side until it completes with nothing accepted
  // anywhere, so the watchdog has to allow a whole shuffle with margin.
  localparam int WATCHDOG_LIMIT = 150000;
  // The slowest single word outside a shuffle is a step with a modulus.
  localparam int SETTLE_CYCLES  = 64;

  // One input word: the action and its two operands.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seed;
    logic [8:0]  index;
  } lcg_word_t;

  // One result word: table entry (reads only) and generator state.
  typedef struct packed {
    logic [7:0]  entry;
    logic [31:0] state;
  } lcg_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // seed_value[31:0], entry_index[40:32], zero
  logic [1:0]  in_tuser = ACT_LOAD; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // entry_value[7:0], random_value[39:8]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lcg_permutation_shuffler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting for the driver, and results the block still owes us.
  lcg_word_t   words_to_send[$];
  lcg_result_t lcg_results_due[$];
  lcg_word_t   word_on_bus;

  // Idle rates of the two sides, in percent; changed only at falling edges.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  // Local copy of the block's state and its generator constants.
  logic [7:0]  perm_copy [TBL_SIZE];
  logic [31:0] lcg_state;
  logic [31:0] mult_copy;
  logic [31:0] incr_copy;
  logic [31:0] mod_copy;

  // One generator step. The modulus only reduces the increment, and the
  // product wraps at 32 bits because the whole expression is 32 bits wide.
  function automatic logic [31:0] lcg_draw();
    logic [31:0] inc;
    inc = incr_copy;
    if (mod_copy != 32'd0) inc = incr_copy % mod_copy;
    lcg_state = mult_copy * lcg_state + inc;
    return lcg_state;
  endfunction

  function automatic void fill_identity();
    for (int pos = 0; pos < TBL_SIZE; pos++) perm_copy[pos] = pos[7:0];
  endfunction

  // Shuffle restarts from the identity, then every position in turn swaps
  // with the one that a fresh draw picks, round after round.
  function automatic void shuffle_copy();
    logic [31:0] pick;
    logic [7:0]  held;
    fill_identity();
    for (int r = 0; r < TBL_ROUNDS; r++) begin
      for (int pos = 0; pos < TBL_SIZE; pos++) begin
        pick = lcg_draw() % TBL_SIZE;
        held = perm_copy[pos];
        perm_copy[pos] = perm_copy[pick];
        perm_copy[pick] = held;
      end
    end
  endfunction

  // Apply one accepted word to the local copy and return what it must yield.
  function automatic lcg_result_t apply_action(lcg_word_t w);
    lcg_result_t res;
    res.entry = 8'd0;
    case (w.action)
      ACT_LOAD: begin
        lcg_state = w.seed;
      end
      ACT_STEP: begin
        void'(lcg_draw());
      end
      ACT_SHUFFLE: begin
        shuffle_copy();
      end
      default: begin
        // Reads index the doubled table, so the index wraps at the table size.
        res.entry = perm_copy[w.index % TBL_SIZE];
      end
    endcase
    res.state = lcg_state;
    return res;
  endfunction

  // Driver. A presented word stays on the bus until it is taken; a new one
  // is offered only when the sender is not idling this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lcg_results_due.push_back(apply_action(word_on_bus));
      end
      if (!in_tvalid || in_tready) begin
        if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          word_on_bus = words_to_send.pop_front();
          in_tdata <= {7'd0, word_on_bus.index, word_on_bus.seed};
          in_tuser <= word_on_bus.action;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void note_mismatch(lcg_result_t want, lcg_result_t got, bit unexpected);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (unexpected)
        $display("%0t: result word with nothing due: entry %0d state %h",
                 $realtime, got.entry, got.state);
      else
        $display("%0t: result word wrong: entry %0d (want %0d) state %h (want %h)",
                 $realtime, got.entry, want.entry, got.state, want.state);
    end
  endfunction

  // Monitor. Backpressure is random at the configured rate; each result word
  // is checked against the oldest one due.
  always @(posedge clk) begin
    lcg_result_t got;
    lcg_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        got.entry = out_tdata[7:0];
        got.state = out_tdata[39:8];
        if (lcg_results_due.size() == 0) begin
          want = '0;
          note_mismatch(want, got, 1'b1);
        end else begin
          want = lcg_results_due.pop_front();
          if (got.entry !== want.entry || got.state !== want.state)
            note_mismatch(want, got, 1'b0);
        end
      end
    end
  end

  // Watchdog: a run of cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One APB write: setup cycle, then access cycle until pready. The local
  // copy is updated at the edge where the block takes the value.
  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (reg_idx)
      REG_LCG_MULT: mult_copy = value;
      REG_LCG_INCR: incr_copy = value;
      default:      mod_copy = value;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_lcg(input logic [31:0] mult, input logic [31:0] incr,
                         input logic [31:0] modulus);
    write_reg(REG_LCG_MULT, mult);
    write_reg(REG_LCG_INCR, incr);
    write_reg(REG_LCG_MOD, modulus);
  endtask

  function automatic void queue_word(logic [1:0] action, logic [31:0] seed,
                                     logic [8:0] index);
    lcg_word_t w;
    w.action = action;
    w.seed = seed;
    w.index = index;
    words_to_send.push_back(w);
  endfunction

  // Random words: mostly steps and reads with some reloads, and exactly one
  // shuffle at a random spot, since a shuffle passes over the whole table in every round.
  // Unused operand fields are random too, so the block must ignore them.
  task automatic queue_random_words(input int count);
    int          shuffle_at;
    int unsigned roll;
    logic [31:0] rnd;
    lcg_word_t   w;
    shuffle_at = $urandom_range(0, count - 1);
    for (int n = 0; n < count; n++) begin
      rnd = $urandom;
      w.seed = $urandom;
      w.index = rnd[8:0];
      roll = $urandom_range(0, 99);
      if (n == shuffle_at) w.action = ACT_SHUFFLE;
      else if (roll < 20) w.action = ACT_LOAD;
      else if (roll < 55) w.action = ACT_STEP;
      else w.action = ACT_READ;
      // Now and then a read right at an edge of the doubled table.
      if (w.action == ACT_READ && roll >= 92) w.index = rnd[9] ? 9'd511 : 9'd256;
      words_to_send.push_back(w);
    end
  endtask

  // Pause the sender until every word is taken and every result is back.
  task automatic wait_until_drained();
    while (words_to_send.size() != 0 || in_tvalid || lcg_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [31:0] rnd;
    lcg_state = 32'd0;
    mult_copy = RST_LCG_MULT;
    incr_copy = RST_LCG_INCR;
    mod_copy = RST_LCG_MOD;
    fill_identity();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the default constants, written out explicitly while
    // the block is still filling its table. The sender idles at 33 percent
    // and the receiver at 51.
    set_lcg(RST_LCG_MULT, RST_LCG_INCR, RST_LCG_MOD);
    send_idle_pct = 33;
    recv_idle_pct = 51;
    // The table must read back as the identity straight after reset, in both
    // halves of the doubled range.
    queue_word(ACT_READ, 32'd0, 9'd0);
    queue_word(ACT_READ, 32'd0, 9'd511);
    queue_word(ACT_READ, 32'hFFFF_FFFF, 9'd256);
    queue_word(ACT_READ, 32'd0, 9'd255);
    queue_word(ACT_READ, 32'd0, 9'd300);
    // Step from the reset state, then from both extremes of the seed.
    queue_word(ACT_STEP, 32'd0, 9'd0);
    queue_word(ACT_LOAD, 32'hFFFF_FFFF, 9'd0);
    queue_word(ACT_STEP, 32'd0, 9'd511);
    queue_word(ACT_LOAD, 32'd0, 9'd511);
    queue_word(ACT_STEP, 32'hFFFF_FFFF, 9'd0);
    queue_word(ACT_LOAD, 32'h1234_5678, 9'd511);
    queue_word(ACT_SHUFFLE, 32'hFFFF_FFFF, 9'd511);
    queue_word(ACT_READ, 32'd0, 9'd0);
    queue_word(ACT_READ, 32'd0, 9'd255);
    queue_word(ACT_READ, 32'd0, 9'd256);
    queue_word(ACT_READ, 32'hFFFF_FFFF, 9'd511);
    queue_word(ACT_READ, 32'd0, 9'd1);
    queue_word(ACT_READ, 32'd0, 9'd257);
    queue_word(ACT_STEP, 32'd0, 9'd0);
    rnd = $urandom;
    queue_word(ACT_LOAD, rnd, 9'd0);
    queue_word(ACT_STEP, 32'd0, 9'd0);
    wait_until_drained();

    // All-ones constants: the modulus swallows the whole increment and the
    // multiplier negates the state on every draw.
    set_lcg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random_words(35);
    wait_until_drained();

    // Rates swapped. A zero multiplier pins the state to the reduced
    // increment, so every shuffle draw picks the same partner.
    send_idle_pct = 51;
    recv_idle_pct = 33;
    rnd = $urandom_range(2, 1000);
    set_lcg(32'd0, 32'hFFFF_FFFF, rnd);
    queue_random_words(30);
    wait_until_drained();

    // No idling from here on. A modulus of one and a zero increment.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rnd = $urandom;
    set_lcg(rnd | 32'd1, 32'd0, 32'd1);
    queue_random_words(15);
    wait_until_drained();

    // Fully random constants.
    set_lcg($urandom, $urandom, $urandom);
    queue_random_words(20);
    wait_until_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && lcg_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
